// ----- hdl/ag1_pkg.sv -----
// ----------------------------------------------------------------------------
// ag1_pkg: shared types and codes for the x86 group-1 ALU
// Operation codes, the flag word layout and the ALU result bundle.
// ----------------------------------------------------------------------------
package ag1_pkg;

    localparam int unsigned DATA_W = 32;

    typedef logic [2:0]        t_kind;
    typedef logic [DATA_W-1:0] t_word;

    localparam t_kind KIND_ADD = 3'd0;
    localparam t_kind KIND_OR  = 3'd1;
    localparam t_kind KIND_ADC = 3'd2;
    localparam t_kind KIND_SBB = 3'd3;
    localparam t_kind KIND_AND = 3'd4;
    localparam t_kind KIND_SUB = 3'd5;
    localparam t_kind KIND_XOR = 3'd6;
    localparam t_kind KIND_CMP = 3'd7;

    // Stored flag word: carry in the lowest bit, zero in the highest.
    typedef struct packed {
        logic zero;
        logic sign;
        logic overflow;
        logic carry;
    } t_flags;

    typedef struct packed {
        t_word  value;
        t_flags flags;
    } t_alu_res;

endpackage

// ----- hdl/ag1_alu.sv -----
// ----------------------------------------------------------------------------
// ag1_alu: combinational group-1 operation unit
// Computes the 32-bit result and the fresh flags for one operation.
// ----------------------------------------------------------------------------
module ag1_alu (
    input  ag1_pkg::t_kind    i_kind,
    input  ag1_pkg::t_word    i_lhs,
    input  ag1_pkg::t_word    i_rhs,
    input  logic              i_carry,
    output ag1_pkg::t_alu_res o_res
);

    logic [ag1_pkg::DATA_W:0]   w_sum;
    logic [ag1_pkg::DATA_W:0]   w_diff;
    logic                       w_cin_add;
    logic                       w_cin_sub;
    ag1_pkg::t_word             w_res;
    logic                       w_cf;
    logic                       w_of;

    // Only adc and sbb consume the stored carry.
    assign w_cin_add = (i_kind == ag1_pkg::KIND_ADC) ? i_carry : 1'b0;
    assign w_cin_sub = (i_kind == ag1_pkg::KIND_SBB) ? i_carry : 1'b0;

    // One extra bit holds the unsigned carry, or the borrow for subtraction.
    assign w_sum  = {1'b0, i_lhs} + {1'b0, i_rhs}
                  + {{ag1_pkg::DATA_W{1'b0}}, w_cin_add};
    assign w_diff = {1'b0, i_lhs} - {1'b0, i_rhs}
                  - {{ag1_pkg::DATA_W{1'b0}}, w_cin_sub};

    always_comb begin
        w_res = '0;
        w_cf  = 1'b0;
        w_of  = 1'b0;
        unique case (i_kind)
            ag1_pkg::KIND_ADD, ag1_pkg::KIND_ADC: begin
                w_res = w_sum[ag1_pkg::DATA_W-1:0];
                w_cf  = w_sum[ag1_pkg::DATA_W];
                w_of  = (i_lhs[ag1_pkg::DATA_W-1] ^ w_res[ag1_pkg::DATA_W-1])
                      & (i_rhs[ag1_pkg::DATA_W-1] ^ w_res[ag1_pkg::DATA_W-1]);
            end
            ag1_pkg::KIND_SBB, ag1_pkg::KIND_SUB, ag1_pkg::KIND_CMP: begin
                w_res = w_diff[ag1_pkg::DATA_W-1:0];
                w_cf  = w_diff[ag1_pkg::DATA_W];
                w_of  = (i_lhs[ag1_pkg::DATA_W-1] ^ i_rhs[ag1_pkg::DATA_W-1])
                      & (i_lhs[ag1_pkg::DATA_W-1] ^ w_res[ag1_pkg::DATA_W-1]);
            end
            ag1_pkg::KIND_OR:  w_res = i_lhs | i_rhs;
            ag1_pkg::KIND_AND: w_res = i_lhs & i_rhs;
            ag1_pkg::KIND_XOR: w_res = i_lhs ^ i_rhs;
            default: w_res = '0;
        endcase
    end

    // Compare returns the left operand but flags the subtraction.
    assign o_res.value          = (i_kind == ag1_pkg::KIND_CMP) ? i_lhs : w_res;
    assign o_res.flags.carry    = w_cf;
    assign o_res.flags.overflow = w_of;
    assign o_res.flags.sign     = w_res[ag1_pkg::DATA_W-1];
    assign o_res.flags.zero     = (w_res == '0);

endmodule

// ----- hdl/x86_group1_alu_with_flags.sv -----
// ----------------------------------------------------------------------------
// x86_group1_alu_with_flags: 32-bit x86 group-1 ALU with a flag register
// Streams add, or, adc, sbb, and, sub, xor and cmp operations and returns
// each result together with the carry, overflow, sign and zero flags.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  tdata                              tuser
//  s_axis   in         [31:0] left, [63:32] right         [2:0] kind, [3] keep
//  m_axis   out        [31:0] value, [32] carry,          none
//                      [33] overflow, [34] sign, [35] zero, [39:36] zero
//
// One item is accepted every cycle while the output side keeps up. An item
// taken into the input register crosses the single ALU stage into the result
// register, from which its result is shown on m_axis.
// The synchronous active-low reset empties both registers and clears the
// stored flags. When the result register is held by m_axis_tready low, the
// input register still fills once, and s_axis_tready drops only when both
// registers hold items.
//
module x86_group1_alu_with_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: left_operand[31:0], right_operand[63:32].
    input  logic [63:0] s_axis_tdata,
    // Fields from bit 0: kind[2:0], keep_flags[3].
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: value[31:0], carry_out[32], overflow_out[33],
    // sign_out[34], zero_out[35], then zero fill up to bit 39.
    output logic [39:0] m_axis_tdata
);

    // Input register.
    logic                r_in_valid;
    ag1_pkg::t_kind      r_in_kind;
    ag1_pkg::t_word      r_in_lhs;
    ag1_pkg::t_word      r_in_rhs;
    logic                r_in_keep;

    // Result register.
    logic                r_out_valid;
    ag1_pkg::t_word      r_out_value;
    ag1_pkg::t_flags     r_out_flags;

    // Architectural flag register.
    ag1_pkg::t_flags     r_flags;
    ag1_pkg::t_flags     n_flags;

    ag1_pkg::t_alu_res   w_alu;
    logic                w_advance;
    logic                w_accept;

    // The item in the input register moves on whenever the result register
    // is empty or is being emptied in this cycle.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    ag1_alu u_alu (
        .i_kind  (r_in_kind),
        .i_lhs   (r_in_lhs),
        .i_rhs   (r_in_rhs),
        .i_carry (r_flags.carry),
        .o_res   (w_alu)
    );

    // The flags change only as an item leaves the ALU stage, so the next item
    // always sees the carry as left by the items before it.
    assign n_flags = r_in_keep ? r_flags : w_alu.flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (w_accept) begin
            r_in_kind <= s_axis_tuser[2:0];
            r_in_keep <= s_axis_tuser[3];
            r_in_lhs  <= s_axis_tdata[31:0];
            r_in_rhs  <= s_axis_tdata[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_advance) begin
            r_out_value <= w_alu.value;
            r_out_flags <= n_flags;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_flags.zero, r_out_flags.sign,
                            r_out_flags.overflow, r_out_flags.carry, r_out_value};

`ifndef NO_ASSERTIONS
    // A shown result always carries the flags currently stored.
    a_out_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_flags == r_flags))
        else $error("result flags differ from stored flags");

    // An item that keeps the flags leaves the flag register alone.
    a_keep_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_keep) |=> (r_flags == $past(r_flags)))
        else $error("flags changed on a keep item");

    // Logic operations that do not keep the flags clear carry and overflow.
    a_logic_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !r_in_keep && (r_in_kind == ag1_pkg::KIND_OR
            || r_in_kind == ag1_pkg::KIND_AND || r_in_kind == ag1_pkg::KIND_XOR))
        |=> (!r_flags.carry && !r_flags.overflow))
        else $error("logic operation left carry or overflow set");

    // An item leaving the ALU stage always lands in the result register.
    a_advance_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("advanced item lost");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stream-level test of the x86 group-1 ALU with its flag register
// A driver sends add, or, adc, sbb, and, sub, xor and cmp items from a queue.
// Each accepted item is run through an independent ALU predictor that keeps
// its own copy of the flag register. A monitor compares every result with
// the oldest prediction; the stream sides stall at random, then run freely.
// ----------------------------------------------------------------------------
module tb;

    // One ALU operation as the driver sees it.
    typedef struct packed {
        ag1_pkg::t_kind kind;
        ag1_pkg::t_word lhs;
        ag1_pkg::t_word rhs;
        logic           keep;
    } t_alu_op;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // Fields from bit 0: left_operand[31:0], right_operand[63:32].
    logic [63:0] s_axis_tdata = '0;
    // Fields from bit 0: kind[2:0], keep_flags[3].
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // Fields from bit 0: value[31:0], carry_out[32], overflow_out[33],
    // sign_out[34], zero_out[35], zero fill up to bit 39.
    logic [39:0] m_axis_tdata;

    // Operations waiting to be driven, and results the block still owes us.
    t_alu_op           ops_to_send[$];
    ag1_pkg::t_alu_res results_due[$];

    // The predictor's own copy of the stored flags. They start at zero, as after reset.
    ag1_pkg::t_flags   model_flags = '0;

    // Chance, in percent, that each side idles in a given cycle.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int unsigned error_count     = 0;
    int unsigned items_sent      = 0;
    int unsigned items_kept      = 0;
    int unsigned results_checked = 0;

    ag1_pkg::t_alu_res want;

    x86_group1_alu_with_flags DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Computes the result of one group-1 operation and advances the model
    // flags. Adc and sbb take the stored carry as an extra unit, even when the
    // flags are held. The 33-bit sum or difference gives the true unsigned
    // carry or borrow in its top bit.
    function automatic ag1_pkg::t_alu_res group1_execute(ag1_pkg::t_kind kind,
                                                         ag1_pkg::t_word lhs,
                                                         ag1_pkg::t_word rhs,
                                                         logic keep);
        logic [32:0]       wide;
        logic              carry_in;
        logic              cf;
        logic              of;
        ag1_pkg::t_word    res;
        ag1_pkg::t_alu_res out;
        carry_in = model_flags.carry;
        cf       = 1'b0;
        of       = 1'b0;
        res      = '0;
        case (kind)
            ag1_pkg::KIND_ADD, ag1_pkg::KIND_ADC: begin
                if (kind == ag1_pkg::KIND_ADD) carry_in = 1'b0;
                wide = {1'b0, lhs} + {1'b0, rhs} + {32'd0, carry_in};
                res  = wide[31:0];
                cf   = wide[32];
                of   = (lhs[31] ^ res[31]) & (rhs[31] ^ res[31]);
            end
            ag1_pkg::KIND_SBB, ag1_pkg::KIND_SUB, ag1_pkg::KIND_CMP: begin
                if (kind != ag1_pkg::KIND_SBB) carry_in = 1'b0;
                // The difference spans -2^32 .. 2^32-1, so bit 32 is the borrow.
                wide = {1'b0, lhs} - {1'b0, rhs} - {32'd0, carry_in};
                res  = wide[31:0];
                cf   = wide[32];
                of   = (lhs[31] ^ rhs[31]) & (lhs[31] ^ res[31]);
            end
            ag1_pkg::KIND_OR:  res = lhs | rhs;
            ag1_pkg::KIND_AND: res = lhs & rhs;
            default:           res = lhs ^ rhs;
        endcase
        if (!keep) begin
            model_flags.carry    = cf;
            model_flags.overflow = of;
            model_flags.sign     = res[31];
            model_flags.zero     = (res == '0);
        end
        // Compare only sets the flags and hands back its left operand.
        out.value = (kind == ag1_pkg::KIND_CMP) ? lhs : res;
        out.flags = model_flags;
        return out;
    endfunction

    function automatic void check_field(string name, logic [31:0] expected,
                                        logic [31:0] actual);
        if (expected !== actual) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expected, actual);
            error_count++;
        end
    endfunction

    // Operands lean on the corners of the 32-bit range, where carry, borrow
    // and overflow change, with fully random words for the rest.
    function automatic ag1_pkg::t_word pick_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return ag1_pkg::t_word'($urandom_range(0, 3));
            5:       return 32'hFFFF_FFFF - ag1_pkg::t_word'($urandom_range(0, 3));
            default: return ag1_pkg::t_word'($urandom);
        endcase
    endfunction

    task automatic queue_op(ag1_pkg::t_kind kind, ag1_pkg::t_word lhs,
                            ag1_pkg::t_word rhs, logic keep);
        t_alu_op op;
        op.kind = kind;
        op.lhs  = lhs;
        op.rhs  = rhs;
        op.keep = keep;
        ops_to_send.push_back(op);
    endtask

    task automatic queue_random_ops(int unsigned count);
        ag1_pkg::t_word lhs;
        ag1_pkg::t_word rhs;
        repeat (count) begin
            lhs = pick_operand();
            rhs = pick_operand();
            // Equal operands now and then, so sub, cmp and xor hit zero.
            if ($urandom_range(0, 9) == 0) rhs = lhs;
            queue_op(ag1_pkg::t_kind'($urandom_range(0, 7)), lhs, rhs,
                     ($urandom_range(0, 4) == 0));
        end
    endtask

    // Waits until every queued item has been sent and every result checked.
    task automatic wait_drained();
        while (ops_to_send.size() != 0 || results_due.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
    endtask

    // Driver. On each accepted item the predictor runs at once, so the model
    // flags advance in the same order as the block's. A new item is loaded only
    // when the bus is free or the current one was just taken; tvalid gets at
    // most one assignment per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                results_due.push_back(group1_execute(s_axis_tuser[2:0],
                                                     s_axis_tdata[31:0],
                                                     s_axis_tdata[63:32],
                                                     s_axis_tuser[3]));
                items_sent++;
                if (s_axis_tuser[3]) items_kept++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (ops_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    t_alu_op op;
                    op = ops_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {op.rhs, op.lhs};
                    s_axis_tuser  <= {op.keep, op.kind};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every accepted result must match the oldest prediction, field
    // by field. The receiver's ready is redrawn every cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    $error("result 0x%0h arrived with no item outstanding", m_axis_tdata);
                    error_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("value", want.value, m_axis_tdata[31:0]);
                    check_field("carry_out", {31'd0, want.flags.carry},
                                {31'd0, m_axis_tdata[32]});
                    check_field("overflow_out", {31'd0, want.flags.overflow},
                                {31'd0, m_axis_tdata[33]});
                    check_field("sign_out", {31'd0, want.flags.sign},
                                {31'd0, m_axis_tdata[34]});
                    check_field("zero_out", {31'd0, want.flags.zero},
                                {31'd0, m_axis_tdata[35]});
                    results_checked++;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Stimulus and run control.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First phase: the sender rarely idles, the receiver mostly stalls.
        send_idle_pct = 7;
        recv_idle_pct = 76;

        // Directed part. Add at the unsigned wrap sets carry and zero.
        queue_op(ag1_pkg::KIND_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        // Adc picks up that carry: 0 + 0 + 1.
        queue_op(ag1_pkg::KIND_ADC, 32'h0000_0000, 32'h0000_0000, 1'b0);
        // Signed overflow into the sign bit.
        queue_op(ag1_pkg::KIND_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
        queue_op(ag1_pkg::KIND_ADD, 32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_op(ag1_pkg::KIND_ADD, 32'h8000_0000, 32'h8000_0000, 1'b0);
        // Largest adc: both operands full with the carry set from before.
        queue_op(ag1_pkg::KIND_ADC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_op(ag1_pkg::KIND_ADC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        // Borrow out of zero, then sbb with a borrow in that wraps exactly.
        queue_op(ag1_pkg::KIND_SUB, 32'h0000_0000, 32'h0000_0001, 1'b0);
        queue_op(ag1_pkg::KIND_SBB, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        queue_op(ag1_pkg::KIND_SBB, 32'h0000_0005, 32'h0000_0002, 1'b0);
        queue_op(ag1_pkg::KIND_SUB, 32'h8000_0000, 32'h0000_0001, 1'b0);
        queue_op(ag1_pkg::KIND_SUB, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        // Compare returns its left operand and only moves the flags.
        queue_op(ag1_pkg::KIND_CMP, 32'h0000_0005, 32'h0000_0005, 1'b0);
        queue_op(ag1_pkg::KIND_CMP, 32'h0000_0000, 32'h0000_0001, 1'b0);
        queue_op(ag1_pkg::KIND_CMP, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        // Logic operations clear carry and overflow.
        queue_op(ag1_pkg::KIND_OR, 32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_op(ag1_pkg::KIND_AND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_op(ag1_pkg::KIND_XOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_op(ag1_pkg::KIND_OR, 32'hAAAA_5555, 32'h5555_AAAA, 1'b0);
        // Held flags: set carry, then items with keep_flags must leave the
        // stored flags alone while adc and sbb still use the carry.
        queue_op(ag1_pkg::KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_op(ag1_pkg::KIND_SUB, 32'h0000_0001, 32'h0000_0001, 1'b1);
        queue_op(ag1_pkg::KIND_ADC, 32'h0000_0000, 32'h0000_0000, 1'b1);
        queue_op(ag1_pkg::KIND_SBB, 32'h0000_0000, 32'h0000_0000, 1'b1);
        queue_op(ag1_pkg::KIND_CMP, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        queue_op(ag1_pkg::KIND_XOR, 32'h1234_5678, 32'h1234_5678, 1'b1);

        queue_random_ops(200);
        wait_drained();

        // Second phase: the sender mostly idles, the receiver rarely stalls.
        send_idle_pct = 76;
        recv_idle_pct = 7;
        queue_random_ops(200);
        wait_drained();

        // Third phase: both sides run flat out.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_ops(200);
        wait_drained();

        // Nothing more is owed; let the two-stage pipe show any stray result.
        repeat (8) @(posedge i_clk);

        $display("Sent %0d ALU items (%0d with flags held) and checked %0d results",
                 items_sent, items_kept, results_checked);
        $display("under three stall patterns, with %0d mismatches.", error_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop if the block hangs. A correct run needs well under a tenth
    // of this even with the heaviest stalls.
    initial begin
        #3_000_000;
        $display("Timed out with %0d items unsent and %0d results owed.",
                 ops_to_send.size(), results_due.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
